>>> sv/sta_pkg.sv
// Shared types, codes and helpers of the sensor threshold alarm table.
package sta_pkg;

	// input item kinds
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	// comparison codes; the two remaining codes never hold
	localparam logic [2:0] CMP_LT = 3'd0;
	localparam logic [2:0] CMP_LE = 3'd1;
	localparam logic [2:0] CMP_EQ = 3'd2;
	localparam logic [2:0] CMP_GE = 3'd3;
	localparam logic [2:0] CMP_GT = 3'd4;
	localparam logic [2:0] CMP_NE = 3'd5;

	localparam int RULE_SLOTS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int FIRE_CNT_W     = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CLEAR,
		OP_SAMPLE
	} op_t;

	// one command between front and back end
	typedef struct packed {
		op_t                op;
		logic [63:0]        key;       // device 63..16, type 15..8, index 7..0
		logic [3:0]         slot;
		logic               enabled;
		logic [2:0]         comparison;
		logic signed [31:0] threshold;
		logic               latched;
		logic signed [31:0] value;
	} cmd_t;

	// rule memory word
	typedef struct packed {
		logic [63:0]        key;
		logic               enabled;
		logic [2:0]         comparison;
		logic signed [31:0] threshold;
	} rule_t;

	typedef struct packed {
		logic [3:0]         slot;
		logic [2:0]         comparison;
		logic signed [31:0] threshold;
		logic               last;
	} result_t;

	function automatic logic cmp_holds(input logic [2:0] code,
			input logic signed [31:0] value, input logic signed [31:0] thr);
		logic r;
		case (code)
			CMP_LT: r = value < thr;
			CMP_LE: r = value <= thr;
			CMP_EQ: r = value == thr;
			CMP_GE: r = value >= thr;
			CMP_GT: r = value > thr;
			CMP_NE: r = value != thr;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/sta_if.sv
// Channel interfaces: sample/rule beats in, alarm beats out.
interface sta_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [47:0]        device_num;
	logic [7:0]         sensor_type_code;
	logic [7:0]         sensor_index;
	logic [3:0]         rule_slot;
	logic               rule_enabled;
	logic [2:0]         comparison;
	logic signed [31:0] threshold;
	logic               initial_latched;
	logic signed [31:0] sample_value;

	modport source(output valid, kind, device_num, sensor_type_code, sensor_index, rule_slot,
		rule_enabled, comparison, threshold, initial_latched, sample_value, input ready);
	modport sink(input valid, kind, device_num, sensor_type_code, sensor_index, rule_slot,
		rule_enabled, comparison, threshold, initial_latched, sample_value, output ready);
endinterface

interface sta_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         fired_slot;
	logic [2:0]         fired_comparison;
	logic signed [31:0] fired_threshold;
	logic               last;

	modport source(output valid, fired_slot, fired_comparison, fired_threshold, last,
		input ready);
	modport sink(input valid, fired_slot, fired_comparison, fired_threshold, last,
		output ready);
endinterface

>>> sv/sta_front.sv
// Front end: takes input beats, decodes the kind, drops no-op items, builds commands.
module sta_front
	import sta_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	sta_in_if.sink req,
	input  logic   full,
	output logic   push,
	output cmd_t   cmd
);

	logic keep;
	logic slot_ok;

	assign req.ready = !full;
	assign slot_ok   = 8'(req.rule_slot) < 8'(RULE_SLOTS);

	always_comb begin
		cmd.key        = {req.device_num, req.sensor_type_code, req.sensor_index};
		cmd.slot       = req.rule_slot;
		cmd.enabled    = req.rule_enabled;
		cmd.comparison = req.comparison;
		cmd.threshold  = req.threshold;
		cmd.latched    = req.initial_latched;
		cmd.value      = req.sample_value;
		case (req.kind)
			KIND_WRITE: begin
				cmd.op = OP_WRITE;
				keep   = slot_ok;   // writes past the table are dropped
			end
			KIND_CLEAR: begin
				cmd.op = OP_CLEAR;
				keep   = 1'b1;
			end
			KIND_SAMPLE: begin
				cmd.op = OP_SAMPLE;
				keep   = 1'b1;
			end
			default: begin
				cmd.op = OP_SAMPLE;
				keep   = 1'b0;
			end
		endcase
	end

	assign push = req.valid && !full && keep;

endmodule

>>> sv/sta_queue.sv
// Short command queue between front and back end.
module sta_queue
	import sta_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/sta_back.sv
// Back end: rule memory, per-slot valid/latched bits, slot scanner and result staging.
module sta_back
	import sta_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	sta_out_if.source rsp
);

	localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic                  valid_q   [RULE_SLOTS];
	logic                  latched_q [RULE_SLOTS];
	logic                  v_s1;
	logic [SLOT_W-1:0]     idx_s1;
	rule_t                 rule_s1;
	logic                  pend_v_q;
	result_t               pend_q;
	logic                  out_v_q;
	result_t               out_q;

	rule_t                 rule_mem [RULE_SLOTS];

	logic              issue, rd_en, wr_en, adv, out_free, stall, last_eval, out_load;
	logic              vld, lat, key_hit, hit, want_fire, dev_hit;
	logic [SLOT_W-1:0] wr_addr;
	rule_t             wr_rule;
	result_t           new_res;

	// memory ports
	assign wr_en   = state_q == ST_IDLE && q_valid && q_cmd.op == OP_WRITE;
	assign wr_addr = SLOT_W'(q_cmd.slot);
	assign wr_rule = '{key: q_cmd.key, enabled: q_cmd.enabled,
		comparison: q_cmd.comparison, threshold: q_cmd.threshold};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_mem[wr_addr] <= wr_rule;
		end
		if (rd_en) begin
			rule_s1 <= rule_mem[rd_cnt_q[SLOT_W-1:0]];
		end
	end

	// evaluation of the slot held in stage 1
	assign vld       = valid_q[idx_s1];
	assign lat       = latched_q[idx_s1];
	assign key_hit   = vld && rule_s1.enabled && rule_s1.key == cmd_q.key;
	assign dev_hit   = vld && rule_s1.key[63:16] == cmd_q.key[63:16];
	assign hit       = cmp_holds(rule_s1.comparison, cmd_q.value, rule_s1.threshold);
	assign want_fire = v_s1 && cmd_q.op == OP_SAMPLE && key_hit && hit && !lat
		&& fire_cnt_q < FIRE_CNT_W'(MAX_RESULTS);

	assign out_free  = !out_v_q || rsp.ready;
	assign stall     = want_fire && pend_v_q && !out_free;
	assign adv       = !stall;
	assign issue     = rd_cnt_q < CNT_W'(RULE_SLOTS);
	assign rd_en     = state_q == ST_SCAN && adv && issue;
	assign last_eval = v_s1 && idx_s1 == SLOT_W'(RULE_SLOTS - 1);
	assign q_pop     = state_q == ST_IDLE && q_valid;

	// the held result moves out once a later one fires (not the last) or at the flush
	assign out_load  = pend_v_q && out_free
		&& ((state_q == ST_SCAN && want_fire) || state_q == ST_FLUSH);

	assign new_res = '{slot: 4'(8'(idx_s1)), comparison: rule_s1.comparison,
		threshold: rule_s1.threshold, last: 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			fire_cnt_q <= '0;
			v_s1       <= 1'b0;
			idx_s1     <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < RULE_SLOTS; i++) begin
				valid_q[i]   <= 1'b0;
				latched_q[i] <= 1'b0;
			end
		end else begin
			if (out_load) begin
				out_q   <= '{slot: pend_q.slot, comparison: pend_q.comparison,
					threshold: pend_q.threshold, last: state_q == ST_FLUSH};
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						if (q_cmd.op == OP_WRITE) begin
							valid_q[wr_addr]   <= 1'b1;
							latched_q[wr_addr] <= q_cmd.latched;
						end else begin
							state_q    <= ST_SCAN;
							rd_cnt_q   <= '0;
							fire_cnt_q <= '0;
							v_s1       <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (adv) begin
						v_s1 <= issue;
						if (issue) begin
							idx_s1   <= rd_cnt_q[SLOT_W-1:0];
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end
						if (v_s1 && cmd_q.op == OP_CLEAR && dev_hit) begin
							valid_q[idx_s1]   <= 1'b0;
							latched_q[idx_s1] <= 1'b0;
						end
						if (v_s1 && cmd_q.op == OP_SAMPLE && key_hit && !hit) begin
							latched_q[idx_s1] <= 1'b0;
						end
						if (want_fire) begin
							latched_q[idx_s1] <= 1'b1;
							fire_cnt_q        <= fire_cnt_q + 1'b1;
							pend_q            <= new_res;
							pend_v_q          <= 1'b1;
						end
						if (last_eval) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = out_v_q;
	assign rsp.fired_slot       = out_q.slot;
	assign rsp.fired_comparison = out_q.comparison;
	assign rsp.fired_threshold  = out_q.threshold;
	assign rsp.last             = out_q.last;

endmodule

>>> sv/sensor_threshold_alarm_table_top.sv
// Top level of the sensor threshold alarm table: front end, command queue, back end.
// Path: a beat is registered in the command queue and then popped by the back end; a
//   rule write lands in rule memory on its pop, the last alarm of a sample at the flush.
// Occupancy: a clear or sample holds the back end for the pop, one slot read per cycle
//   while alarms do not back up, the last evaluate and the flush; a write, its pop only.
// Reset: arst_n clears valid/latched bits, queue and output register at once; no pass.
module sensor_threshold_alarm_table_top
	import sta_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF   // 1 to 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sta_in_if.sink    req,
	sta_out_if.source rsp
);

	// front to queue
	logic push;
	logic full;
	cmd_t push_cmd;

	// queue to back end
	logic pop;
	logic pop_valid;
	cmd_t pop_cmd;

	// Front decodes the beat; kind 3 and writes past the table are taken and dropped.
	sta_front #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_front (
		.req  (req),
		.full (full),
		.push (push),
		.cmd  (push_cmd)
	);

	// Two commands of slack so the input side keeps taking beats during a scan.
	sta_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	// Back end scans slots in ascending order; one result is held back so the
	// final one of a sample can carry last.
	sta_back #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_cmd   (pop_cmd),
		.q_pop   (pop),
		.rsp     (rsp)
	);

endmodule

>>> sv/sta_checker.sv
// Port-level checks on the alarm output of the table, bound to the top level.
module sta_checker
	import sta_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         fired_slot,
	input logic [2:0]         fired_comparison,
	input logic signed [31:0] fired_threshold,
	input logic               last
);

	logic       in_burst_q;
	logic [3:0] prev_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_burst_q  <= 1'b0;
			prev_slot_q <= '0;
		end else if (out_valid && out_ready) begin
			in_burst_q  <= !last;
			prev_slot_q <= fired_slot;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("alarm beat dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({fired_slot, fired_comparison,
			fired_threshold, last}))
		else $error("alarm payload changed while stalled");

	a_never_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fired_comparison != 3'd6 && fired_comparison != 3'd7)
		else $error("rule with a never-holding comparison fired");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (RULE_SLOTS >= 16) || (7'(fired_slot) < 7'(RULE_SLOTS)))
		else $error("fired slot beyond table");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_burst_q |-> (RULE_SLOTS > 16) || (fired_slot > prev_slot_q))
		else $error("alarms of one sample out of slot order");

endmodule

bind sensor_threshold_alarm_table_top sta_checker #(
	.RULE_SLOTS(RULE_SLOTS)
) u_sta_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (rsp.valid),
	.out_ready        (rsp.ready),
	.fired_slot       (rsp.fired_slot),
	.fired_comparison (rsp.fired_comparison),
	.fired_threshold  (rsp.fired_threshold),
	.last             (rsp.last)
);
